[design/jse_pkg.sv]
package jse_pkg;

  localparam int unsigned MaxRun = 6;

  localparam logic [7:0] ChrBackslash = 8'h5C;
  localparam logic [7:0] ChrQuote     = 8'h22;
  localparam logic [7:0] ChrSlash     = 8'h2F;
  localparam logic [7:0] ChrZero      = 8'h30;
  localparam logic [7:0] ChrU         = 8'h75;
  localparam logic [7:0] ChrB         = 8'h62;
  localparam logic [7:0] ChrT         = 8'h74;
  localparam logic [7:0] ChrN         = 8'h6E;
  localparam logic [7:0] ChrF         = 8'h66;
  localparam logic [7:0] ChrR         = 8'h72;

  localparam logic [7:0] CtlBackspace = 8'h08;
  localparam logic [7:0] CtlTab       = 8'h09;
  localparam logic [7:0] CtlNewline   = 8'h0A;
  localparam logic [7:0] CtlFormFeed  = 8'h0C;
  localparam logic [7:0] CtlReturn    = 8'h0D;
  localparam logic [7:0] CtlLimit     = 8'h20;
  localparam logic [7:0] HighLimit    = 8'h80;

  typedef logic [2:0] run_len_t;

  typedef struct packed {
    run_len_t                 len;
    logic [MaxRun-1:0][7:0]   bytes;
  } esc_run_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = 8'h30 + {4'd0, nib};
    end else begin
      d = 8'h57 + {4'd0, nib};
    end
    return d;
  endfunction

endpackage

[design/jse_in_if.sv]
interface jse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

[design/jse_out_if.sv]
interface jse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

[design/jse_escape.sv]
module jse_escape (
  input  logic [7:0]       byte_i,
  input  logic             stop_at_nul_i,
  input  logic             terminated_i,
  output jse_pkg::esc_run_t run_o
);

  always_comb begin
    run_o = '0;
    if (terminated_i || (byte_i == 8'd0 && stop_at_nul_i)) begin
      run_o.len = 3'd0;
    end else if (byte_i >= jse_pkg::HighLimit) begin
      run_o.len      = 3'd1;
      run_o.bytes[0] = byte_i;
    end else if (byte_i < jse_pkg::CtlLimit) begin
      run_o.bytes[0] = jse_pkg::ChrBackslash;
      run_o.len      = 3'd2;
      unique case (byte_i)
        jse_pkg::CtlBackspace: run_o.bytes[1] = jse_pkg::ChrB;
        jse_pkg::CtlTab:       run_o.bytes[1] = jse_pkg::ChrT;
        jse_pkg::CtlNewline:   run_o.bytes[1] = jse_pkg::ChrN;
        jse_pkg::CtlFormFeed:  run_o.bytes[1] = jse_pkg::ChrF;
        jse_pkg::CtlReturn:    run_o.bytes[1] = jse_pkg::ChrR;
        default: begin
          run_o.len      = 3'd6;
          run_o.bytes[1] = jse_pkg::ChrU;
          run_o.bytes[2] = jse_pkg::ChrZero;
          run_o.bytes[3] = jse_pkg::ChrZero;
          run_o.bytes[4] = jse_pkg::hex_digit(byte_i[7:4]);
          run_o.bytes[5] = jse_pkg::hex_digit(byte_i[3:0]);
        end
      endcase
    end else if (byte_i == jse_pkg::ChrQuote || byte_i == jse_pkg::ChrBackslash ||
                 byte_i == jse_pkg::ChrSlash) begin
      run_o.len      = 3'd2;
      run_o.bytes[0] = jse_pkg::ChrBackslash;
      run_o.bytes[1] = byte_i;
    end else begin
      run_o.len      = 3'd1;
      run_o.bytes[0] = byte_i;
    end
  end

endmodule

[design/jse_serialiser.sv]
module jse_serialiser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  jse_pkg::esc_run_t run_i,
  output logic              can_load_o,
  jse_out_if.source         out_o
);

  logic [jse_pkg::MaxRun-1:0][7:0] buf_q, buf_d;
  jse_pkg::run_len_t               cnt_q, cnt_d;
  logic                            fire;

  assign fire              = out_o.valid && out_o.ready;
  assign out_o.valid       = (cnt_q != 3'd0);
  assign out_o.out_byte    = buf_q[0];
  assign out_o.last_of_run = (cnt_q == 3'd1);
  assign can_load_o        = (cnt_q == 3'd0) || (fire && cnt_q == 3'd1);

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (load_i) begin
      buf_d = run_i.bytes;
      cnt_d = run_i.len;
    end else if (fire) begin
      buf_d = {8'd0, buf_q[jse_pkg::MaxRun-1:1]};
      cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

[design/json_string_escaper.sv]
// JSON string escaper: takes one source byte a beat on in_i and gives its escaped
// form on out_o, one byte a beat, with last_of_run marking the final byte of each
// source byte's run (one, two or six bytes; none for a dropped byte). A byte is
// registered on entry and its run is loaded into a six-byte output shift
// register; a new byte is taken once the final byte of the previous run leaves,
// so a byte that expands to two or six bytes holds the input while the register
// drains, one byte a cycle while out_o is ready; a beat passes the input register
// and then the output shift register. With stop_at_nul set (its reset value), a
// zero byte and every later byte up to and including the end_of_string beat give
// no output; write cfg_wdata_i only while the block is idle.
module json_string_escaper (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  jse_in_if.sink    in_i,
  jse_out_if.source out_o
);

  logic              in_valid_q;
  logic [7:0]        byte_q;
  logic              eos_q;
  logic              stop_at_nul_q;
  logic              terminated_q, terminated_d;
  logic              can_load;
  logic              advance;
  jse_pkg::esc_run_t run;

  assign advance    = in_valid_q && can_load;
  assign in_i.ready = !in_valid_q || can_load;

  always_comb begin
    terminated_d = terminated_q;
    if (advance) begin
      if (terminated_q) begin
        terminated_d = !eos_q;
      end else if (byte_q == 8'd0 && stop_at_nul_q) begin
        terminated_d = !eos_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      stop_at_nul_q <= 1'b1;
      terminated_q  <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (cfg_we_i) begin
        stop_at_nul_q <= cfg_wdata_i;
      end
      terminated_q <= terminated_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.in_byte;
      eos_q  <= in_i.end_of_string;
    end
  end

  jse_escape u_escape (
    .byte_i        (byte_q),
    .stop_at_nul_i (stop_at_nul_q),
    .terminated_i  (terminated_q),
    .run_o         (run)
  );

  jse_serialiser u_serialiser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance && run.len != 3'd0),
    .run_i      (run),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule

[design/jse_checker.sv]
module jse_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       last_of_run_i
);

  // no raw control byte ever leaves the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_byte_i >= jse_pkg::CtlLimit)
    else $error("control byte on output");

  // quote and slash only leave as the second byte of an escape pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_byte_i == jse_pkg::ChrQuote || out_byte_i == jse_pkg::ChrSlash))
      |-> last_of_run_i)
    else $error("quote or slash not at end of run");

  // the rest of a run follows the beat straight away
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !last_of_run_i) |=> out_valid_i)
    else $error("gap inside a run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_byte_i) && $stable(last_of_run_i)))
    else $error("stalled output beat changed");

endmodule

bind json_string_escaper jse_checker u_jse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .last_of_run_i (out_o.last_of_run)
);
